// File: design/stb_pkg.sv
// Shared types, codes and constants for the software timer bank.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package stb_pkg;

    localparam int unsigned DEFAULT_SLOTS = 16;
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam int unsigned ID_W          = 5;
    localparam int unsigned DELAY_W       = 20;

    localparam logic [DELAY_W-1:0] DELAY_CAP      = 20'hFFFFF;
    localparam logic [DELAY_W-1:0] MIN_WAKE_RESET = 20'd33;

    // register index decoded from the word address
    localparam logic REG_MIN_WAKE = 1'b0;

    localparam logic [2:0] FUNC_ALLOC = 3'd0;
    localparam logic [2:0] FUNC_FREE  = 3'd1;
    localparam logic [2:0] FUNC_START = 3'd2;
    localparam logic [2:0] FUNC_STOP  = 3'd3;
    localparam logic [2:0] FUNC_TICK  = 3'd4;

    localparam logic [1:0] KIND_ALLOC  = 2'd0;
    localparam logic [1:0] KIND_EXPIRY = 2'd1;
    localparam logic [1:0] KIND_WAKE   = 2'd2;

    typedef enum logic [2:0] {
        OP_ALLOC = 3'd0,
        OP_FREE  = 3'd1,
        OP_START = 3'd2,
        OP_STOP  = 3'd3,
        OP_TICK  = 3'd4
    } stb_op_t;

    typedef enum logic [1:0] {
        SLOT_FREE     = 2'd0,
        SLOT_INACTIVE = 2'd1,
        SLOT_READY    = 2'd2,
        SLOT_ACTIVE   = 2'd3
    } slot_status_t;

    typedef struct packed {
        logic [2:0]      func;
        logic [ID_W-1:0] timer_id;
        logic [31:0]     now;
        logic [31:0]     interval;
        logic            periodic;
        logic            notify;
    } stb_in_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [ID_W-1:0]    slot;
        logic [DELAY_W-1:0] next_delay;
        logic               last;
    } stb_out_t;

    typedef struct packed {
        stb_op_t         op;
        logic [ID_W-1:0] id;
        logic [31:0]     now;
        logic [31:0]     interval;
        logic            periodic;
        logic            notify;
    } stb_cmd_t;

endpackage

`default_nettype wire

// File: design/software_timer_bank_top.sv
// Top level of the software timer bank: front end, command queue, slot
// engine and the min_wake register. Depends on stb_pkg and the stb_* modules.
//
// Usage:
//   Commands arrive on cmd (cmd_valid/cmd_ready) and results leave on rsp
//   (rsp_valid/rsp_ready); a transfer happens when valid and ready are high.
//   Alloc gives one result, tick gives one result per notifying expiry and
//   then a next wake delay result with last set; free, start and stop give
//   none. min_wake is written over the APB port at byte address 0.
// Command flow:
//   A command enters a two-entry queue; alloc, free, start and stop are run
//   by the slot engine from the queue head, and the result of an alloc is
//   registered in the output register once the alloc leaves the queue. A tick
//   takes the elapsed time, walks the slots one at a time on the single
//   compare-and-subtract unit, folds the last countdown into the minimum,
//   then loads the wake result.
// Reset: all slots free, previous tick zero, min_wake 33, queue empty.
// Stall: while a result waits in the output register, alloc and the tick
//   walk hold; the queue keeps accepting commands until it is full.
`timescale 1ns / 1ps
`default_nettype none

module software_timer_bank_top
    import stb_pkg::*;
#(
    parameter int unsigned SLOTS = DEFAULT_SLOTS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire stb_in_t     cmd,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output stb_out_t         rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic               q_ready;
    logic               q_push;
    stb_cmd_t           q_in;
    logic               q_pop;
    logic               q_valid;
    stb_cmd_t           q_out;
    logic [DELAY_W-1:0] min_wake_reg, min_wake_next;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        min_wake_next = min_wake_reg;
        if (cfg_wr && (paddr[2] == REG_MIN_WAKE))
        begin
            min_wake_next = pwdata[DELAY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_wake_reg <= MIN_WAKE_RESET;
        end
        else
        begin
            min_wake_reg <= min_wake_next;
        end
    end

    assign prdata = (paddr[2] == REG_MIN_WAKE) ? {12'd0, min_wake_reg} : 32'd0;

    stb_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_cmd     (q_in)
    );

    stb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (q_out)
    );

    stb_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .min_wake  (min_wake_reg),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// File: design/stb_front.sv
// Front end: decodes each input transfer into a command and drops no-ops.
// Depends on stb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stb_front
    import stb_pkg::*;
#(
    parameter int unsigned SLOTS = DEFAULT_SLOTS
) (
    input  wire logic     cmd_valid,
    output logic          cmd_ready,
    input  wire stb_in_t  cmd,
    input  wire logic     q_ready,
    output logic          q_push,
    output stb_cmd_t      q_cmd
);

    logic    keep;
    logic    id_ok;
    stb_op_t op;

    assign id_ok = ({1'b0, cmd.timer_id} < (ID_W + 1)'(SLOTS));

    always_comb
    begin
        keep = 1'b0;
        op   = OP_ALLOC;
        case (cmd.func)
            FUNC_ALLOC:
            begin
                op   = OP_ALLOC;
                keep = 1'b1;
            end
            FUNC_FREE:
            begin
                op   = OP_FREE;
                keep = id_ok;
            end
            FUNC_START:
            begin
                op   = OP_START;
                keep = id_ok;
            end
            FUNC_STOP:
            begin
                op   = OP_STOP;
                keep = id_ok;
            end
            FUNC_TICK:
            begin
                op   = OP_TICK;
                keep = 1'b1;
            end
            default:
            begin
                op   = OP_ALLOC;
                keep = 1'b0;
            end
        endcase
    end

    // accept whenever the queue has room; drop commands with no effect
    assign cmd_ready      = q_ready;
    assign q_push         = cmd_valid && q_ready && keep;
    assign q_cmd.op       = op;
    assign q_cmd.id       = cmd.timer_id;
    assign q_cmd.now      = cmd.now;
    assign q_cmd.interval = cmd.interval;
    assign q_cmd.periodic = cmd.periodic;
    assign q_cmd.notify   = cmd.notify;

endmodule

`default_nettype wire

// File: design/stb_queue.sv
// Short command queue between the front end and the slot engine.
// Depends on stb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stb_queue
    import stb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire stb_cmd_t push_data,
    output logic          ready,
    input  wire logic     pop,
    output logic          valid,
    output stb_cmd_t      data
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    stb_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign ready   = (count_reg != CNT_FULL);
    assign valid   = (count_reg != '0);
    assign data    = entry_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: design/stb_back.sv
// Slot engine: holds the slot table, runs commands and the tick walk,
// and drives the result register. Depends on stb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stb_back
    import stb_pkg::*;
#(
    parameter int unsigned SLOTS = DEFAULT_SLOTS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire stb_cmd_t           q_data,
    output logic                    q_pop,
    input  wire logic [DELAY_W-1:0] min_wake,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output stb_out_t                rsp
);

    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
    localparam logic [ID_W-1:0]  NONE_CODE = ID_W'(SLOTS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_FLUSH = 4'b0100,
        S_FINAL = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    slot_status_t       status_reg [SLOTS];
    logic               periodic_reg [SLOTS];
    logic               notify_reg [SLOTS];
    logic [31:0]        interval_reg [SLOTS];
    logic [31:0]        countdown_reg [SLOTS];

    logic [31:0]        prev_reg, prev_next;
    logic [31:0]        delta_reg, delta_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [DELAY_W-1:0] min_reg, min_next;
    logic               cand_vld_reg, cand_vld_next;
    logic [31:0]        cand_val_reg, cand_val_next;
    logic               rsp_valid_reg, rsp_valid_next;
    stb_out_t           rsp_reg, rsp_next;

    logic               out_free;
    logic               rsp_load;
    logic               st_we;
    logic [IDX_W-1:0]   st_widx;
    slot_status_t       st_wval;
    logic               ld_we;
    logic               zero_we;
    logic               cd_we;
    logic [31:0]        cd_wval;
    logic [IDX_W-1:0]   cmd_idx;
    slot_status_t       cmd_status;
    logic               found;
    logic [IDX_W-1:0]   found_idx;
    slot_status_t       walk_status;
    logic [31:0]        walk_cd;
    logic [31:0]        walk_cd_dec;
    logic               walk_alive;

    assign out_free    = !rsp_valid_reg || rsp_ready;
    assign cmd_idx     = q_data.id[IDX_W-1:0];
    assign cmd_status  = status_reg[cmd_idx];
    assign walk_status = status_reg[idx_reg];
    assign walk_cd     = countdown_reg[idx_reg];
    assign walk_cd_dec = walk_cd - delta_reg;
    assign walk_alive  = walk_cd > delta_reg;

    // lowest free slot for alloc
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (status_reg[i] == SLOT_FREE)
            begin
                found     = 1'b1;
                found_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        q_pop          = 1'b0;
        prev_next      = prev_reg;
        delta_next     = delta_reg;
        idx_next       = idx_reg;
        min_next       = min_reg;
        cand_vld_next  = 1'b0;
        cand_val_next  = cand_val_reg;
        rsp_load       = 1'b0;
        rsp_next       = rsp_reg;
        st_we          = 1'b0;
        st_widx        = cmd_idx;
        st_wval        = SLOT_FREE;
        ld_we          = 1'b0;
        zero_we        = 1'b0;
        cd_we          = 1'b0;
        cd_wval        = interval_reg[idx_reg];

        // fold the previous walk step into the running minimum
        if (cand_vld_reg && (cand_val_reg < {12'd0, min_reg}))
        begin
            min_next = cand_val_reg[DELAY_W-1:0];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_data.op)
                        OP_ALLOC:
                        begin
                            if (out_free)
                            begin
                                q_pop           = 1'b1;
                                rsp_load        = 1'b1;
                                rsp_next.kind   = KIND_ALLOC;
                                rsp_next.slot   = found ? ID_W'(found_idx) : NONE_CODE;
                                rsp_next.next_delay = '0;
                                rsp_next.last   = 1'b1;
                                st_we           = found;
                                st_widx         = found_idx;
                                st_wval         = SLOT_INACTIVE;
                            end
                        end
                        OP_FREE:
                        begin
                            q_pop   = 1'b1;
                            zero_we = 1'b1;
                            st_we   = 1'b1;
                            st_wval = SLOT_FREE;
                        end
                        OP_START:
                        begin
                            q_pop   = 1'b1;
                            ld_we   = 1'b1;
                            st_we   = 1'b1;
                            st_wval = (cmd_status == SLOT_FREE) ? SLOT_FREE : SLOT_READY;
                        end
                        OP_STOP:
                        begin
                            q_pop   = 1'b1;
                            zero_we = 1'b1;
                            st_we   = 1'b1;
                            st_wval = (cmd_status == SLOT_READY || cmd_status == SLOT_ACTIVE)
                                      ? SLOT_INACTIVE : cmd_status;
                        end
                        OP_TICK:
                        begin
                            q_pop      = 1'b1;
                            delta_next = q_data.now - prev_reg;
                            prev_next  = q_data.now;
                            idx_next   = '0;
                            min_next   = DELAY_CAP;
                            state_next = S_WALK;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (out_free)
                begin
                    st_widx = idx_reg;
                    case (walk_status)
                        SLOT_READY:
                        begin
                            st_we         = 1'b1;
                            st_wval       = SLOT_ACTIVE;
                            cand_vld_next = 1'b1;
                            cand_val_next = walk_cd;
                        end
                        SLOT_ACTIVE:
                        begin
                            if (walk_alive)
                            begin
                                cd_we         = 1'b1;
                                cd_wval       = walk_cd_dec;
                                cand_vld_next = 1'b1;
                                cand_val_next = walk_cd_dec;
                            end
                            else
                            begin
                                if (periodic_reg[idx_reg])
                                begin
                                    cd_we         = 1'b1;
                                    cd_wval       = interval_reg[idx_reg];
                                    cand_vld_next = 1'b1;
                                    cand_val_next = interval_reg[idx_reg];
                                end
                                else
                                begin
                                    st_we   = 1'b1;
                                    st_wval = SLOT_INACTIVE;
                                end
                                if (notify_reg[idx_reg])
                                begin
                                    rsp_load            = 1'b1;
                                    rsp_next.kind       = KIND_EXPIRY;
                                    rsp_next.slot       = ID_W'(idx_reg);
                                    rsp_next.next_delay = '0;
                                    rsp_next.last       = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_FLUSH:
            begin
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    rsp_load            = 1'b1;
                    rsp_next.kind       = KIND_WAKE;
                    rsp_next.slot       = '0;
                    rsp_next.next_delay = (min_reg < min_wake) ? min_wake : min_reg;
                    rsp_next.last       = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_valid_next = rsp_load || (rsp_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_reg      <= '0;
            cand_vld_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                status_reg[i] <= SLOT_FREE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            cand_vld_reg  <= cand_vld_next;
            rsp_valid_reg <= rsp_valid_next;
            if (st_we)
            begin
                status_reg[st_widx] <= st_wval;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg    <= delta_next;
        idx_reg      <= idx_next;
        min_reg      <= min_next;
        cand_val_reg <= cand_val_next;
        rsp_reg      <= rsp_next;
        if (ld_we)
        begin
            interval_reg[cmd_idx]  <= q_data.interval;
            countdown_reg[cmd_idx] <= q_data.interval;
            periodic_reg[cmd_idx]  <= q_data.periodic;
            notify_reg[cmd_idx]    <= q_data.notify;
        end
        else if (zero_we)
        begin
            interval_reg[cmd_idx]  <= '0;
            countdown_reg[cmd_idx] <= '0;
            notify_reg[cmd_idx]    <= 1'b0;
        end
        else if (cd_we)
        begin
            countdown_reg[idx_reg] <= cd_wval;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("command popped from an empty queue");

    a_idle_no_cand: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_FINAL) |-> !cand_vld_reg)
        else $error("walk candidate pending outside the walk");

    a_final_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINAL) |->
            ($past(state_reg) == S_FLUSH || $past(state_reg) == S_FINAL))
        else $error("wake result reached without finishing the walk");

    a_expiry_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_load && rsp_next.kind == KIND_EXPIRY) |-> (state_reg == S_WALK))
        else $error("expiry result outside the tick walk");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |-> out_free)
        else $error("result register overwritten while held");

endmodule

`default_nettype wire

// File: tb/software_timer_bank_top_test.sv
// Self-checking bench for software_timer_bank_top: directed and random commands, min_wake
// writes over APB, an in-bench timer bank model and an in-order result scoreboard.
// Depends on stb_pkg and the software_timer_bank_top RTL.
`timescale 1ns / 1ps

module software_timer_bank_top_test;
    import stb_pkg::*;

    localparam int unsigned NSLOT         = 16;
    localparam int unsigned IDLE_LIMIT    = 3000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned REPORT_MAX    = 10;

    localparam logic [ID_W-1:0] NONE_SLOT      = ID_W'(NSLOT % 32);
    localparam logic [2:0]      FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0]      FUNC_UNUSED_HI = 3'd7;
    localparam logic [2:0]      MIN_WAKE_ADDR  = {REG_MIN_WAKE, 2'b00};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    stb_in_t     cmd       = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    stb_out_t    rsp;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    // timer bank model
    slot_status_t       timer_state    [NSLOT];
    logic               timer_periodic [NSLOT];
    logic               timer_notify   [NSLOT];
    logic [31:0]        timer_interval [NSLOT];
    logic [31:0]        timer_count    [NSLOT];
    logic [31:0]        last_tick_seen;
    logic [DELAY_W-1:0] wake_floor;

    stb_out_t expected_rsp[$];

    int unsigned error_count     = 0;
    int unsigned results_checked = 0;
    int unsigned expiry_events   = 0;
    int unsigned cmds_sent       = 0;
    int unsigned ticks_sent      = 0;
    int unsigned stall_cycles    = 0;
    logic [31:0] stim_now        = '0;
    bit          cmd_gaps_on     = 1'b1;
    bit          rsp_gaps_on     = 1'b1;
    bit          rsp_long_hold   = 1'b0;

    software_timer_bank_top #(
        .SLOTS(NSLOT)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    function automatic stb_out_t rsp_word(logic [1:0] kind, logic [ID_W-1:0] slot,
                                          logic [DELAY_W-1:0] delay, logic last);
        stb_out_t r;
        r.kind       = kind;
        r.slot       = slot;
        r.next_delay = delay;
        r.last       = last;
        return r;
    endfunction

    function automatic void halt_timer(int id);
        if (timer_state[id] == SLOT_READY || timer_state[id] == SLOT_ACTIVE)
            timer_state[id] = SLOT_INACTIVE;
    endfunction

    function automatic void clear_timer(int id);
        halt_timer(id);
        timer_interval[id] = '0;
        timer_count[id]    = '0;
        timer_notify[id]   = 1'b0;
    endfunction

    function automatic void predict_cmd(stb_in_t c);
        int          id;
        bit          found;
        logic [31:0] delta;
        logic [31:0] nearest;
        logic [ID_W-1:0] got;
        id = c.timer_id;
        case (c.func)
            FUNC_ALLOC:
            begin
                got   = NONE_SLOT;
                found = 1'b0;
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (!found && timer_state[i] == SLOT_FREE)
                    begin
                        timer_state[i] = SLOT_INACTIVE;
                        got            = ID_W'(i);
                        found          = 1'b1;
                    end
                end
                expected_rsp.push_back(rsp_word(KIND_ALLOC, got, '0, 1'b1));
            end
            FUNC_FREE:
            begin
                if (id < NSLOT)
                begin
                    clear_timer(id);
                    timer_state[id] = SLOT_FREE;
                end
            end
            FUNC_START:
            begin
                if (id < NSLOT)
                begin
                    halt_timer(id);
                    timer_interval[id] = c.interval;
                    timer_count[id]    = c.interval;
                    timer_periodic[id] = c.periodic;
                    timer_notify[id]   = c.notify;
                    if (timer_state[id] == SLOT_INACTIVE)
                        timer_state[id] = SLOT_READY;
                end
            end
            FUNC_STOP:
            begin
                if (id < NSLOT)
                    clear_timer(id);
            end
            FUNC_TICK:
            begin
                delta          = c.now - last_tick_seen;
                last_tick_seen = c.now;
                nearest        = {12'h000, DELAY_CAP};
                for (int i = 0; i < NSLOT; i++)
                begin
                    // a ready slot only arms on this tick
                    if (timer_state[i] == SLOT_READY)
                        timer_state[i] = SLOT_ACTIVE;
                    else if (timer_state[i] == SLOT_ACTIVE)
                    begin
                        if (timer_count[i] > delta)
                            timer_count[i] = timer_count[i] - delta;
                        else
                        begin
                            if (timer_periodic[i])
                                timer_count[i] = timer_interval[i];
                            else
                                timer_state[i] = SLOT_INACTIVE;
                            if (timer_notify[i])
                                expected_rsp.push_back(rsp_word(KIND_EXPIRY, ID_W'(i),
                                                                '0, 1'b0));
                        end
                    end
                end
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (timer_state[i] == SLOT_ACTIVE && timer_count[i] < nearest)
                        nearest = timer_count[i];
                end
                if (nearest < {12'h000, wake_floor})
                    nearest = {12'h000, wake_floor};
                expected_rsp.push_back(rsp_word(KIND_WAKE, '0, nearest[DELAY_W-1:0], 1'b1));
            end
            default: ;
        endcase
    endfunction

    function automatic void check_rsp(stb_out_t got);
        stb_out_t want;
        results_checked++;
        if (got.kind == KIND_EXPIRY)
            expiry_events++;
        if (expected_rsp.size() == 0)
        begin
            error_count++;
            if (error_count <= REPORT_MAX)
                $display("%0t: unexpected result kind=%0d slot=%0d delay=%0h last=%0d",
                         $realtime, got.kind, got.slot, got.next_delay, got.last);
        end
        else
        begin
            want = expected_rsp.pop_front();
            if (got.kind !== want.kind || got.slot !== want.slot ||
                got.next_delay !== want.next_delay || got.last !== want.last)
            begin
                error_count++;
                if (error_count <= REPORT_MAX)
                begin
                    $display("%0t: result error exp kind=%0d slot=%0d delay=%0h last=%0d",
                             $realtime, want.kind, want.slot, want.next_delay, want.last);
                    $display("    got kind=%0d slot=%0d delay=%0h last=%0d",
                             got.kind, got.slot, got.next_delay, got.last);
                end
            end
        end
    endfunction

    // check finished results first, then predict for the command taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                check_rsp(rsp);
            if (cmd_valid && cmd_ready)
                predict_cmd(cmd);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", stall_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random hold-off per result, plus one long hold on request
    initial
    begin : rsp_side
        int unsigned gap;
        forever
        begin
            if (rsp_long_hold)
            begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                rsp_long_hold = 1'b0;
            end
            gap = rsp_gaps_on ? $urandom_range(0, 19) : 0;
            if (gap != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!(rsp_valid && rsp_ready));
        end
    end

    function automatic stb_in_t make_cmd(logic [2:0] func, logic [ID_W-1:0] id,
                                         logic [31:0] now, logic [31:0] ival,
                                         logic per, logic ntf);
        stb_in_t c;
        c.func     = func;
        c.timer_id = id;
        c.now      = now;
        c.interval = ival;
        c.periodic = per;
        c.notify   = ntf;
        return c;
    endfunction

    task automatic send_cmd(stb_in_t c);
        int unsigned gap;
        gap = cmd_gaps_on ? $urandom_range(0, 19) : 0;
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (!(cmd_valid && cmd_ready));
        cmds_sent++;
        if (c.func == FUNC_TICK)
        begin
            ticks_sent++;
            stim_now = c.now;
        end
    endtask

    // drop valid, let the model catch the last transfer, drain, then settle
    task automatic wait_idle();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (expected_rsp.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_wake(logic [DELAY_W-1:0] value, logic [11:0] upper);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MIN_WAKE_ADDR;
        pwdata  <= {upper, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        wake_floor  = value;
    endtask

    task automatic run_mixed_traffic(int unsigned count);
        stb_in_t     c;
        int unsigned done_items;
        int unsigned pick;
        bit          ignored;
        done_items = 0;
        while (done_items < count)
        begin
            c.timer_id = ($urandom_range(0, 99) < 85) ? ID_W'($urandom_range(0, NSLOT - 1))
                                                       : ID_W'($urandom_range(NSLOT, 31));
            c.now      = $urandom;
            c.interval = $urandom;
            c.periodic = 1'($urandom_range(0, 1));
            c.notify   = ($urandom_range(0, 1) != 0);
            pick       = $urandom_range(0, 99);
            if (pick < 14)
                c.func = FUNC_ALLOC;
            else if (pick < 44)
            begin
                c.func = FUNC_START;
                // short intervals keep expiries coming
                if ($urandom_range(0, 9) < 7)
                    c.interval = $urandom_range(0, 200);
                c.notify = ($urandom_range(0, 4) != 0);
            end
            else if (pick < 72)
            begin
                c.func = FUNC_TICK;
                if ($urandom_range(0, 19) != 0)
                    c.now = stim_now + $urandom_range(0, 150);
            end
            else if (pick < 82)
                c.func = FUNC_STOP;
            else if (pick < 90)
                c.func = FUNC_FREE;
            else if (pick < 96)
                c.func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
            else
                c.func = 3'($urandom_range(0, 7));
            ignored = (c.func > FUNC_TICK) ||
                      (c.func != FUNC_ALLOC && c.func != FUNC_TICK && c.timer_id >= NSLOT);
            send_cmd(c);
            if (!ignored)
                done_items++;
        end
    endtask

    // fill the bank, hit the none reply, then free and reuse
    task automatic test_alloc_until_full();
        for (int i = 0; i <= NSLOT; i++)
            send_cmd(make_cmd(FUNC_ALLOC, '0, '0, '0, 1'b0, 1'b0));
        send_cmd(make_cmd(FUNC_FREE, 5'd7, '0, '0, 1'b0, 1'b0));
        send_cmd(make_cmd(FUNC_ALLOC, '0, '0, '0, 1'b0, 1'b0));
        send_cmd(make_cmd(FUNC_FREE, 5'd12, '0, '0, 1'b0, 1'b0));
        // stop and start on a free slot leave it free
        send_cmd(make_cmd(FUNC_STOP, 5'd12, '0, '0, 1'b0, 1'b0));
        send_cmd(make_cmd(FUNC_START, 5'd12, '0, 32'd3, 1'b1, 1'b1));
    endtask

    task automatic test_timer_corner_cases();
        send_cmd(make_cmd(FUNC_START, 5'd0, '0, 32'd0, 1'b1, 1'b1));
        send_cmd(make_cmd(FUNC_START, 5'd1, '0, 32'hFFFF_FFFF, 1'b0, 1'b1));
        send_cmd(make_cmd(FUNC_START, 5'd2, '0, 32'd40, 1'b0, 1'b1));
        send_cmd(make_cmd(FUNC_START, 5'd31, '0, 32'd9, 1'b1, 1'b1));
        send_cmd(make_cmd(FUNC_UNUSED_HI, 5'd2, $urandom, $urandom, 1'b1, 1'b1));
        send_cmd(make_cmd(FUNC_TICK, '0, 32'hFFFF_FFFF, $urandom, 1'b0, 1'b0));
        // wraps through zero
        send_cmd(make_cmd(FUNC_TICK, '0, 32'h0000_0010, '0, 1'b0, 1'b0));
        send_cmd(make_cmd(FUNC_START, 5'd2, '0, 32'd5, 1'b0, 1'b1));
        send_cmd(make_cmd(FUNC_TICK, '0, 32'h0000_0020, '0, 1'b0, 1'b0));
        send_cmd(make_cmd(FUNC_STOP, 5'd0, '0, '0, 1'b0, 1'b0));
        send_cmd(make_cmd(FUNC_TICK, '0, 32'h0000_0025, '0, 1'b0, 1'b0));
        wait_idle();
    endtask

    task automatic test_random_traffic(int unsigned count);
        cmd_gaps_on = 1'b1;
        rsp_gaps_on = 1'b1;
        run_mixed_traffic(count);
        wait_idle();
    endtask

    // hold results off while commands keep coming, then pause the sender until drained
    task automatic test_backpressure(int unsigned count);
        cmd_gaps_on   = 1'b0;
        rsp_long_hold = 1'b1;
        run_mixed_traffic(count);
        wait_idle();
        cmd_gaps_on = 1'b1;
    endtask

    task automatic test_no_idle_stretch(int unsigned count);
        cmd_gaps_on = 1'b0;
        rsp_gaps_on = 1'b0;
        run_mixed_traffic(count);
        wait_idle();
        cmd_gaps_on = 1'b1;
        rsp_gaps_on = 1'b1;
    endtask

    initial
    begin
        for (int i = 0; i < NSLOT; i++)
        begin
            timer_state[i]    = SLOT_FREE;
            timer_periodic[i] = 1'b0;
            timer_notify[i]   = 1'b0;
            timer_interval[i] = '0;
            timer_count[i]    = '0;
        end
        last_tick_seen = '0;
        wake_floor     = MIN_WAKE_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_alloc_until_full();
        test_timer_corner_cases();

        write_min_wake(20'd1, 12'($urandom));
        test_random_traffic(35);
        write_min_wake(DELAY_CAP, 12'h000);
        test_random_traffic(20);
        write_min_wake(20'($urandom_range(1, 20'hFFFFF)), 12'($urandom));
        test_backpressure(20);
        write_min_wake(MIN_WAKE_RESET, 12'h000);
        test_random_traffic(20);
        write_min_wake(20'd1, 12'hFFF);
        test_no_idle_stretch(20);

        if (expected_rsp.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_rsp.size());
            error_count += expected_rsp.size();
        end
        $display("Ran %0d commands (%0d ticks) across alloc exhaustion, restarts and wraps,",
                 cmds_sent, ticks_sent);
        $display("checked %0d results (%0d expiries) under min_wake 1, 33, max and random.",
                 results_checked, expiry_events);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
design/stb_pkg.sv
design/stb_front.sv
design/stb_queue.sv
design/stb_back.sv
design/software_timer_bank_top.sv
tb/software_timer_bank_top_test.sv
